@@ design/dwv_pkg.sv @@
// Shared types and constants for the dual wheel velocity PID core.
package dwv_pkg;

   // Operation codes carried by a request word
   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_STOP   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // Register indexes (byte address 4*index)
   typedef enum logic [2:0] {
      REG_PERIOD = 3'd0,
      REG_KP     = 3'd1,
      REG_KI     = 3'd2,
      REG_KD     = 3'd3,
      REG_LIMIT  = 3'd4
   } reg_index_type;

   localparam int ADDR_W = 5;

   localparam logic [15:0] PERIOD_RESET = 16'd500;
   localparam logic [15:0] KP_RESET     = 16'd72;
   localparam logic [15:0] KI_RESET     = 16'd51;
   localparam logic [15:0] KD_RESET     = 16'd20;
   localparam logic [9:0]  LIMIT_RESET  = 10'd220;

   // Configuration as seen by the lanes
   typedef struct packed {
      logic [15:0] kp;
      logic [15:0] ki;
      logic [15:0] kd;
      logic [9:0]  limit;
   } cfg_type;

   // Commands from the controller to a lane
   typedef struct packed {
      logic start;
      logic clear;
      logic go;
   } lane_cmd_type;

   // Lane status back to the controller
   typedef struct packed {
      logic busy;
      logic done;
   } lane_stat_type;

endpackage

@@ design/dwv_if.sv @@
// Request and response channel interfaces.
interface dwv_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] now_ms;
   logic [31:0] odo_left;
   logic [31:0] odo_right;
   logic [15:0] set_left;
   logic [15:0] set_right;

   modport source (output valid, op, now_ms, odo_left, odo_right, set_left, set_right,
                   input ready);
   modport sink   (input valid, op, now_ms, odo_left, odo_right, set_left, set_right,
                   output ready);
endinterface

interface dwv_rsp_if #(parameter int DRIVE_W = 9);
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive_left;
   logic signed [DRIVE_W-1:0] drive_right;

   modport source (output valid, drive_left, drive_right, input ready);
   modport sink   (input valid, drive_left, drive_right, output ready);
endinterface

@@ design/dwv_div.sv @@
// Bit-serial signed by unsigned divider, truncating toward zero, one bit per cycle.
module dwv_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] dividend,
   input  logic [31:0]        divisor,
   output logic               done,
   output logic signed [63:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic [63:0] quot_ff, quot_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] shifted;
   logic [32:0] trial;

   assign shifted = {rem_ff, quot_ff[63]};
   assign trial   = shifted - {1'b0, dvs_ff};

   // One restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = dividend[63];
         quot_in = dividend[63] ? 64'(-dividend) : 64'(dividend);
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in  = trial[31:0];
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in  = shifted[31:0];
            quot_in = {quot_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -signed'(quot_ff) : signed'(quot_ff);

endmodule

@@ design/dwv_lane.sv @@
// One wheel lane: target latch, speed, error, integral and PID update sequencer.
module dwv_lane #(
   parameter int FRAC_BITS = 8,
   parameter int DRIVE_MAX = 255,
   parameter int MAG_W     = 8,
   parameter int DRIVE_W   = 9
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dwv_pkg::lane_cmd_type     cmd,
   input  dwv_pkg::cfg_type          cfg,
   input  logic [15:0]               per,
   input  logic [31:0]               elapsed,
   input  logic [31:0]               odo,
   input  logic [15:0]               set_val,
   output dwv_pkg::lane_stat_type    stat,
   output logic signed [DRIVE_W-1:0] drive
);

   localparam int SK_W = 13 + FRAC_BITS;
   localparam logic signed [SK_W:0] SPEED_K  = (SK_W+1)'(6000 << FRAC_BITS);
   localparam logic signed [10:0]   THOUSAND = 11'sd1000;
   localparam int SHIFT = FRAC_BITS + 8;
   // ceil(2^36 / 125): exact x/1000 for any 32-bit x as ((x >> 3) * K) >> 36
   localparam logic [29:0] RECIP_125 = 30'd549755814;

   typedef enum logic [3:0] {
      L_IDLE, L_MSPD, L_WSPD, L_ERR, L_IQ, L_IR, L_IP, L_IS, L_IACC,
      L_MDE, L_MDK, L_WDER, L_MP, L_MI, L_SUM, L_FIN
   } lstate_type;

   lstate_type         state_ff;
   logic [9:0]         tmag_ff;
   logic               neg_ff;
   logic [31:0]        last_cnt_ff;
   logic signed [39:0] integ_ff;
   logic signed [31:0] prev_ff;
   logic [MAG_W-1:0]   mag_ff;
   logic [31:0]        odo_ff;
   logic [15:0]        per_ff;
   logic [31:0]        el_ff;
   logic signed [31:0] err_ff;
   logic signed [63:0] prod_ff;
   logic signed [63:0] pacc_ff;
   logic signed [63:0] sum_ff;
   logic               div_go_ff;
   logic               done_ff;
   logic [31:0]        a_ff;
   logic [31:0]        c_ff;
   logic [9:0]         b_ff;
   logic [9:0]         r_ff;
   logic [63:0]        p1_ff;
   logic [31:0]        p2_ff;
   logic [19:0]        rb_ff;
   logic [63:0]        istep_ff;

   logic               div_done;
   logic signed [63:0] div_q;
   logic [31:0]        div_b;

   logic signed [31:0] delta;
   logic [16:0]        set_abs;
   logic [9:0]         tmag_new;
   logic               neg_new;
   logic signed [63:0] tmag_fx;
   logic signed [63:0] err_diff;
   logic signed [31:0] err_sat;
   logic [31:0]        eabs;
   logic signed [63:0] istep_s;
   logic signed [63:0] isum;
   logic signed [39:0] isat;
   logic signed [32:0] de;
   logic signed [16:0] kp_s, ki_s, kd_s;
   logic signed [63:0] mag_fx;
   logic signed [63:0] sum_sh;
   logic [MAG_W-1:0]   mag_new;

   // Unsigned 32-bit divide by 1000 through a reciprocal multiply
   function automatic logic [31:0] div_by_1000(input logic [31:0] x);
      logic [59:0] prod;
      prod = 60'(x[31:3]) * 60'(RECIP_125);
      return 32'(prod[59:36]);
   endfunction

   // Target clamp to the speed limit
   assign set_abs  = set_val[15] ? 17'(-$signed({set_val[15], set_val}))
                                 : {1'b0, set_val};
   assign tmag_new = (set_abs > {7'b0, cfg.limit}) ? cfg.limit : set_abs[9:0];
   assign neg_new  = set_val[15] && (cfg.limit != '0);

   // Operand views
   assign delta   = signed'(odo_ff - last_cnt_ff);
   assign kp_s    = signed'({1'b0, cfg.kp});
   assign ki_s    = signed'({1'b0, cfg.ki});
   assign kd_s    = signed'({1'b0, cfg.kd});
   assign de      = 33'(err_ff) - 33'(prev_ff);
   assign tmag_fx = signed'(64'(tmag_ff) << FRAC_BITS);
   assign mag_fx  = signed'(64'(mag_ff) << SHIFT);
   assign eabs    = err_ff[31] ? 32'(-err_ff) : 32'(err_ff);

   // Error saturation to 32 bits
   assign err_diff = tmag_fx - div_q;
   always_comb begin
      if (err_diff > 64'sd2147483647)
         err_sat = 32'sh7fffffff;
      else if (err_diff < -64'sd2147483648)
         err_sat = 32'sh80000000;
      else
         err_sat = err_diff[31:0];
   end

   // Integral step carries the sign of the error; saturation to 40 bits
   assign istep_s = err_ff[31] ? -signed'(istep_ff) : signed'(istep_ff);
   assign isum    = 64'(integ_ff) + istep_s;
   always_comb begin
      if (isum > 64'sd549755813887)
         isat = 40'sh7fffffffff;
      else if (isum < -64'sd549755813888)
         isat = 40'sh8000000000;
      else
         isat = isum[39:0];
   end

   // Drive magnitude clamp
   assign sum_sh = sum_ff >>> SHIFT;
   always_comb begin
      if (sum_ff < 0)
         mag_new = '0;
      else if (sum_sh > 64'(DRIVE_MAX))
         mag_new = MAG_W'(DRIVE_MAX);
      else
         mag_new = sum_sh[MAG_W-1:0];
   end

   // Divisor select by the phase waiting on the divider
   always_comb begin
      case (state_ff)
         L_WSPD:  div_b = 32'(per_ff);
         default: div_b = el_ff;
      endcase
   end

   dwv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (prod_ff),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   // Sequencer and lane state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= L_IDLE;
         div_go_ff   <= 1'b0;
         done_ff     <= 1'b0;
         tmag_ff     <= '0;
         neg_ff      <= 1'b0;
         last_cnt_ff <= '0;
         integ_ff    <= '0;
         prev_ff     <= '0;
         mag_ff      <= '0;
      end else begin
         div_go_ff <= 1'b0;
         done_ff   <= 1'b0;
         unique case (state_ff)
            L_IDLE: begin
               if (cmd.clear) begin
                  tmag_ff     <= '0;
                  neg_ff      <= 1'b0;
                  last_cnt_ff <= '0;
                  integ_ff    <= '0;
                  prev_ff     <= '0;
                  mag_ff      <= '0;
               end else if (cmd.start) begin
                  tmag_ff     <= tmag_new;
                  neg_ff      <= neg_new;
                  last_cnt_ff <= odo;
               end else if (cmd.go) begin
                  odo_ff   <= odo;
                  per_ff   <= per;
                  el_ff    <= elapsed;
                  state_ff <= L_MSPD;
               end
            end
            L_MSPD: begin
               prod_ff   <= delta * SPEED_K;
               div_go_ff <= 1'b1;
               state_ff  <= L_WSPD;
            end
            L_WSPD: if (div_done) state_ff <= L_ERR;
            L_ERR: begin
               err_ff   <= err_sat;
               state_ff <= L_IQ;
            end
            // |err|*elapsed/1000 split as elapsed = 1000a+b, |err| = 1000c+r
            L_IQ: begin
               a_ff     <= div_by_1000(el_ff);
               c_ff     <= div_by_1000(eabs);
               state_ff <= L_IR;
            end
            L_IR: begin
               b_ff     <= 10'(el_ff - a_ff * 32'd1000);
               r_ff     <= 10'(eabs - c_ff * 32'd1000);
               state_ff <= L_IP;
            end
            L_IP: begin
               p1_ff    <= 64'(eabs) * 64'(a_ff);
               p2_ff    <= c_ff * 32'(b_ff);
               rb_ff    <= 20'(r_ff) * 20'(b_ff);
               state_ff <= L_IS;
            end
            L_IS: begin
               istep_ff <= p1_ff + 64'(p2_ff) + 64'(div_by_1000(32'(rb_ff)));
               state_ff <= L_IACC;
            end
            L_IACC: begin
               integ_ff <= isat;
               state_ff <= L_MDE;
            end
            L_MDE: begin
               prod_ff  <= de * kd_s;
               state_ff <= L_MDK;
            end
            L_MDK: begin
               prod_ff   <= signed'(prod_ff[49:0]) * THOUSAND;
               div_go_ff <= 1'b1;
               state_ff  <= L_WDER;
            end
            L_WDER: if (div_done) state_ff <= L_MP;
            L_MP: begin
               pacc_ff  <= err_ff * kp_s;
               state_ff <= L_MI;
            end
            L_MI: begin
               pacc_ff  <= pacc_ff + integ_ff * ki_s;
               state_ff <= L_SUM;
            end
            L_SUM: begin
               sum_ff   <= mag_fx + pacc_ff + div_q;
               state_ff <= L_FIN;
            end
            L_FIN: begin
               mag_ff      <= mag_new;
               prev_ff     <= err_ff;
               last_cnt_ff <= odo_ff;
               done_ff     <= 1'b1;
               state_ff    <= L_IDLE;
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign stat.busy = (state_ff != L_IDLE);
   assign stat.done = done_ff;
   assign drive = neg_ff ? -signed'({1'b0, mag_ff}) : signed'({1'b0, mag_ff});

endmodule

@@ design/dual_wheel_velocity_pid_core.sv @@
// Top level: register port, controller and merge of the two wheel lanes.
//
//  channel  | direction | handshake     | payload
//  req_ch   | in        | valid/ready   | op, now_ms, odo_left/right, set_left/right
//  rsp_ch   | out       | valid/ready   | drive_left, drive_right
//  csr      | in        | APB write/read| period_ms, kp/ki/kd_gain, speed_limit
//
// A start or ignored word is taken without leaving the idle state; a stop result passes
// the output state into the response register. A sample that runs has its result valid
// in the same cycle as the next word can be taken; each lane's serial divider runs twice
// (speed, derivative term), the integral step uses a reciprocal multiply.
// Both lanes run in lockstep; the merge registers both drives as one response word.
// A held response does not block the next request; a new result waits for it.
// Reset is synchronous and clears all control state and the registers to defaults.
module dual_wheel_velocity_pid_core #(
   parameter int FRAC_BITS = 8,
   parameter int DRIVE_MAX = 255
) (
   input  logic                       clock,
   input  logic                       reset,
   dwv_req_if.sink                    req_ch,
   dwv_rsp_if.source                  rsp_ch,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [dwv_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   localparam int MAG_W   = $clog2(DRIVE_MAX + 1);
   localparam int DRIVE_W = MAG_W + 1;

   typedef enum logic [1:0] {T_IDLE, T_RUN, T_OUT} tstate_type;

   tstate_type state_ff;
   logic [15:0] period_ff, kp_ff, ki_ff, kd_ff;
   logic [9:0]  limit_ff;
   logic        running_ff;
   logic [31:0] last_time_ff;
   logic        rsp_valid_ff;
   logic signed [DRIVE_W-1:0] rsp_l_ff, rsp_r_ff, res_l_ff, res_r_ff;

   logic                   accept, wr;
   dwv_pkg::reg_index_type idx;
   dwv_pkg::cfg_type       cfg;
   dwv_pkg::lane_cmd_type  cmd;
   dwv_pkg::lane_stat_type stat_l, stat_r;
   logic signed [DRIVE_W-1:0] drive_l, drive_r;
   logic [15:0] per;
   logic [31:0] elapsed;
   logic        is_start, is_stop, is_run;

   // Register port
   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign idx    = dwv_pkg::reg_index_type'(paddr[4:2]);

   always_comb begin
      unique case (idx)
         dwv_pkg::REG_PERIOD: prdata = 32'(period_ff);
         dwv_pkg::REG_KP:     prdata = 32'(kp_ff);
         dwv_pkg::REG_KI:     prdata = 32'(ki_ff);
         dwv_pkg::REG_KD:     prdata = 32'(kd_ff);
         dwv_pkg::REG_LIMIT:  prdata = 32'(limit_ff);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= dwv_pkg::PERIOD_RESET;
         kp_ff     <= dwv_pkg::KP_RESET;
         ki_ff     <= dwv_pkg::KI_RESET;
         kd_ff     <= dwv_pkg::KD_RESET;
         limit_ff  <= dwv_pkg::LIMIT_RESET;
      end else if (wr) begin
         unique case (idx)
            dwv_pkg::REG_PERIOD: period_ff <= pwdata[15:0];
            dwv_pkg::REG_KP:     kp_ff     <= pwdata[15:0];
            dwv_pkg::REG_KI:     ki_ff     <= pwdata[15:0];
            dwv_pkg::REG_KD:     kd_ff     <= pwdata[15:0];
            dwv_pkg::REG_LIMIT:  limit_ff  <= pwdata[9:0];
            default: ;
         endcase
      end
   end

   assign cfg.kp    = kp_ff;
   assign cfg.ki    = ki_ff;
   assign cfg.kd    = kd_ff;
   assign cfg.limit = limit_ff;

   // Request decode
   assign req_ch.ready = (state_ff == T_IDLE);
   assign accept   = req_ch.valid && req_ch.ready;
   assign per      = (period_ff == '0) ? 16'd1 : period_ff;
   assign elapsed  = req_ch.now_ms - last_time_ff;
   assign is_start = accept && (dwv_pkg::op_type'(req_ch.op) == dwv_pkg::OP_START);
   assign is_stop  = accept && (dwv_pkg::op_type'(req_ch.op) == dwv_pkg::OP_STOP);
   assign is_run   = accept && (dwv_pkg::op_type'(req_ch.op) == dwv_pkg::OP_SAMPLE)
                     && running_ff && (elapsed >= 32'(per));

   assign cmd.start = is_start;
   assign cmd.clear = is_stop;
   assign cmd.go    = is_run;

   dwv_lane #(.FRAC_BITS(FRAC_BITS), .DRIVE_MAX(DRIVE_MAX), .MAG_W(MAG_W),
              .DRIVE_W(DRIVE_W)) u_lane_l (
      .clock(clock), .reset(reset), .cmd(cmd), .cfg(cfg), .per(per),
      .elapsed(elapsed), .odo(req_ch.odo_left), .set_val(req_ch.set_left),
      .stat(stat_l), .drive(drive_l)
   );

   dwv_lane #(.FRAC_BITS(FRAC_BITS), .DRIVE_MAX(DRIVE_MAX), .MAG_W(MAG_W),
              .DRIVE_W(DRIVE_W)) u_lane_r (
      .clock(clock), .reset(reset), .cmd(cmd), .cfg(cfg), .per(per),
      .elapsed(elapsed), .odo(req_ch.odo_right), .set_val(req_ch.set_right),
      .stat(stat_r), .drive(drive_r)
   );

   // Controller, merge and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         running_ff   <= 1'b0;
         last_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != T_OUT))
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            T_IDLE: begin
               if (is_start) begin
                  running_ff   <= 1'b1;
                  last_time_ff <= req_ch.now_ms;
               end else if (is_stop) begin
                  running_ff   <= 1'b0;
                  last_time_ff <= '0;
                  res_l_ff     <= '0;
                  res_r_ff     <= '0;
                  state_ff     <= T_OUT;
               end else if (is_run) begin
                  last_time_ff <= req_ch.now_ms;
                  state_ff     <= T_RUN;
               end
            end
            T_RUN: begin
               if (stat_l.done && stat_r.done) begin
                  res_l_ff <= drive_l;
                  res_r_ff <= drive_r;
                  state_ff <= T_OUT;
               end
            end
            T_OUT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_l_ff     <= res_l_ff;
                  rsp_r_ff     <= res_r_ff;
                  state_ff     <= T_IDLE;
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.drive_left  = rsp_l_ff;
   assign rsp_ch.drive_right = rsp_r_ff;

   // Lanes run in lockstep
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      stat_l.done == stat_r.done) else $error("lane done mismatch");

   // Lanes are quiet whenever a request can be taken
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == T_IDLE |-> !stat_l.busy && !stat_r.busy)
      else $error("lane busy while controller idle");

   // A stop always leads to a pending response
   a_stop_out: assert property (@(posedge clock) disable iff (reset)
      is_stop |=> state_ff == T_OUT) else $error("stop did not queue a response");

   // Running clears on stop
   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      is_stop |=> !running_ff) else $error("stop left controller running");

endmodule

@@ sim/tb_dual_wheel_velocity_pid_core.sv @@
// Self-checking testbench for the dual wheel velocity PID core.
module tb_dual_wheel_velocity_pid_core;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 300;
   localparam int PHASES = 9;
   localparam int WORDS_PER_PHASE = 160;
   localparam int DIR_ROWS = 18;
   localparam longint INTEG_MAX = 64'sd549755813887;
   localparam longint INTEG_MIN = -64'sd549755813888;

   typedef struct {
      dwv_pkg::op_type op;
      logic [31:0] now;
      logic [31:0] ol;
      logic [31:0] orr;
      logic [15:0] sl;
      logic [15:0] sr;
      bit          fixed;
      logic [8:0]  el;
      logic [8:0]  er;
   } stim_row;

   typedef struct {
      logic [8:0] dl;
      logic [8:0] dr;
   } drive_pair;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [dwv_pkg::ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   dwv_req_if req_ch ();
   dwv_rsp_if #(.DRIVE_W(9)) rsp_ch ();

   dual_wheel_velocity_pid_core DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Register shadow
   logic [15:0] period_r, kp_r, ki_r, kd_r;
   logic [9:0]  limit_r;

   // Controller state shadow, index 0 left, 1 right
   bit          run_on;
   logic [31:0] t_last;
   logic [31:0] cnt [2];
   logic [9:0]  tmag [2];
   bit          neg [2];
   longint      integ [2];
   longint      perr [2];
   int          mag [2];

   drive_pair drive_q [$];
   int  errors = 0;
   int  quiet_cycles = 0;
   bit  no_idle = 1'b0;

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic void clear_ctl();
      run_on = 0;
      t_last = '0;
      for (int w = 0; w < 2; w++) begin
         cnt[w] = '0; tmag[w] = '0; neg[w] = 0;
         integ[w] = 0; perr[w] = 0; mag[w] = 0;
      end
   endfunction

   function automatic void latch_target(int w, logic [15:0] set);
      longint lim, v;
      lim = longint'(limit_r);
      v = clamp(longint'($signed(set)), -lim, lim);
      neg[w] = v < 0;
      tmag[w] = 10'(v < 0 ? -v : v);
   endfunction

   // One wheel update, returns the new drive magnitude
   function automatic int wheel_update(int w, logic [31:0] odo, longint per,
                                       longint elapsed);
      longint delta, speed, err, de, pid, sum, m;
      delta = longint'($signed(odo - cnt[w]));
      speed = (delta * 6000 * 256) / per;
      err = clamp((longint'(tmag[w]) <<< 8) - speed, -64'sd2147483648, 64'sd2147483647);
      integ[w] = clamp(integ[w] + (err * elapsed) / 1000, INTEG_MIN, INTEG_MAX);
      de = err - perr[w];
      pid = longint'(kp_r) * err + longint'(ki_r) * integ[w]
            + (longint'(kd_r) * de * 1000) / elapsed;
      sum = (longint'(mag[w]) <<< 16) + pid;
      m = sum < 0 ? 0 : (sum >>> 16);
      if (m > 255) m = 255;
      mag[w] = int'(m);
      cnt[w] = odo;
      perr[w] = err;
      return mag[w];
   endfunction

   // Predict the drive word caused by one request word
   function automatic bit predict_drive(dwv_pkg::op_type op, logic [31:0] now,
                                        logic [31:0] ol, logic [31:0] orr,
                                        logic [15:0] sl, logic [15:0] sr,
                                        output drive_pair res);
      longint per, elapsed;
      int ml, mr;
      res = '{9'd0, 9'd0};
      case (op)
         dwv_pkg::OP_START: begin
            latch_target(0, sl);
            latch_target(1, sr);
            cnt[0] = ol; cnt[1] = orr;
            t_last = now;
            run_on = 1;
            return 0;
         end
         dwv_pkg::OP_STOP: begin
            clear_ctl();
            return 1;
         end
         dwv_pkg::OP_SAMPLE: begin
            if (!run_on) return 0;
            per = period_r == 0 ? 1 : longint'(period_r);
            elapsed = longint'({32'd0, now - t_last});
            if (elapsed < per) return 0;
            ml = wheel_update(0, ol, per, elapsed);
            mr = wheel_update(1, orr, per, elapsed);
            t_last = now;
            res.dl = neg[0] ? 9'(-ml) : 9'(ml);
            res.dr = neg[1] ? 9'(-mr) : 9'(mr);
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   // Register write with read-back
   task automatic csr_write(dwv_pkg::reg_index_type idx, logic [31:0] val);
      logic [31:0] mask;
      mask = idx == dwv_pkg::REG_LIMIT ? 32'h3FF : 32'hFFFF;
      @(negedge clock);
      psel = 1; penable = 0; pwrite = 1; paddr = dwv_pkg::ADDR_W'(4 * idx); pwdata = val;
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      penable = 0; pwrite = 0;
      @(negedge clock);
      penable = 1;
      @(posedge clock);
      if ((prdata & mask) !== (val & mask)) begin
         $display("%0t reg %s read-back: expected %h, actual %h", $time, idx.name(),
                  val & mask, prdata & mask);
         errors++;
      end
      @(negedge clock);
      psel = 0; penable = 0;
      case (idx)
         dwv_pkg::REG_PERIOD: period_r = val[15:0];
         dwv_pkg::REG_KP:     kp_r = val[15:0];
         dwv_pkg::REG_KI:     ki_r = val[15:0];
         dwv_pkg::REG_KD:     kd_r = val[15:0];
         default:             limit_r = val[9:0];
      endcase
   endtask

   // Drive one request word; returns once it has been taken
   task automatic send_word(stim_row row);
      drive_pair res;
      bit hit;
      @(negedge clock);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_ch.valid = 0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_ch.valid = 1;
      req_ch.op = row.op; req_ch.now_ms = row.now;
      req_ch.odo_left = row.ol; req_ch.odo_right = row.orr;
      req_ch.set_left = row.sl; req_ch.set_right = row.sr;
      do @(posedge clock); while (!req_ch.ready);
      hit = predict_drive(row.op, row.now, row.ol, row.orr, row.sl, row.sr, res);
      if (row.fixed) drive_q.push_back('{row.el, row.er});
      else if (hit) drive_q.push_back(res);
   endtask

   // Wait for every expected word, then let the core settle
   task automatic drain();
      @(negedge clock);
      req_ch.valid = 0;
      while (drive_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Response back-pressure in bursts
   int stall_left = 0;
   always @(negedge clock) begin
      if (no_idle || reset) begin
         rsp_ch.ready = 1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready = 0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_ch.ready = 0;
      end else begin
         rsp_ch.ready = 1;
      end
   end

   // Response checker
   always @(posedge clock) begin
      drive_pair want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (drive_q.size() == 0) begin
            $display("%0t unexpected drive word: actual %0d %0d", $time,
                     rsp_ch.drive_left, rsp_ch.drive_right);
            errors++;
         end else begin
            want = drive_q.pop_front();
            if (rsp_ch.drive_left !== want.dl) begin
               $display("%0t drive_left: expected %0d, actual %0d", $time,
                        $signed(want.dl), rsp_ch.drive_left);
               errors++;
            end
            if (rsp_ch.drive_right !== want.dr) begin
               $display("%0t drive_right: expected %0d, actual %0d", $time,
                        $signed(want.dr), rsp_ch.drive_right);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (psel && penable) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t watchdog expired", $time);
         $display("*** FAILED ***");
         $finish;
      end
   end

   stim_row dir_tab [DIR_ROWS];
   stim_row row;
   logic [31:0] ms_now;
   logic [31:0] odo [2];
   longint per_eff, step, span;
   int pick;

   initial begin
      req_ch.valid = 0; req_ch.op = dwv_pkg::OP_NONE; req_ch.now_ms = '0;
      req_ch.odo_left = '0; req_ch.odo_right = '0;
      req_ch.set_left = '0; req_ch.set_right = '0;
      rsp_ch.ready = 1;
      period_r = dwv_pkg::PERIOD_RESET; kp_r = dwv_pkg::KP_RESET; ki_r = dwv_pkg::KI_RESET;
      kd_r = dwv_pkg::KD_RESET; limit_r = dwv_pkg::LIMIT_RESET;
      clear_ctl();

      // Directed words: reset values, extremes, wrap, restart, stop
      dir_tab[0]  = '{dwv_pkg::OP_STOP, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 1, 9'd0, 9'd0};
      dir_tab[1]  = '{dwv_pkg::OP_SAMPLE, 32'd9999, 32'd7, 32'd7, 16'd0, 16'd0,
                      0, 9'd0, 9'd0};
      dir_tab[2]  = '{dwv_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      16'hFFFF, 16'hFFFF, 0, 9'd0, 9'd0};
      dir_tab[3]  = '{dwv_pkg::OP_START, 32'd1000, 32'd0, 32'd0, 16'h7FFF, 16'h8000,
                      0, 9'd0, 9'd0};
      dir_tab[4]  = '{dwv_pkg::OP_SAMPLE, 32'd1499, 32'd5, 32'd5, 16'd0, 16'd0,
                      0, 9'd0, 9'd0};
      dir_tab[5]  = '{dwv_pkg::OP_SAMPLE, 32'd1500, 32'd18, -32'sd18, 16'd0, 16'd0,
                      0, 9'd0, 9'd0};
      dir_tab[6]  = '{dwv_pkg::OP_SAMPLE, 32'd2000, 32'h7FFF_FFFF, 32'h8000_0000,
                      16'd0, 16'd0, 0, 9'd0, 9'd0};
      dir_tab[7]  = '{dwv_pkg::OP_SAMPLE, 32'd2500, 32'h8000_0000, 32'h7FFF_FFFF,
                      16'd0, 16'd0, 0, 9'd0, 9'd0};
      dir_tab[8]  = '{dwv_pkg::OP_START, 32'hFFFF_FF00, 32'd5, -32'sd5, 16'd100,
                      -16'sd100, 0, 9'd0, 9'd0};
      dir_tab[9]  = '{dwv_pkg::OP_SAMPLE, 32'h0000_0200, 32'd12, -32'sd12, 16'd0, 16'd0,
                      0, 9'd0, 9'd0};
      dir_tab[10] = '{dwv_pkg::OP_SAMPLE, 32'h0000_01FF, 32'd20, 32'd20, 16'd0, 16'd0,
                      0, 9'd0, 9'd0};
      dir_tab[11] = '{dwv_pkg::OP_START, 32'd100, 32'd0, 32'd0, 16'd0, 16'hFFFF,
                      0, 9'd0, 9'd0};
      dir_tab[12] = '{dwv_pkg::OP_SAMPLE, 32'd600, 32'd0, 32'd0, 16'd0, 16'd0,
                      0, 9'd0, 9'd0};
      dir_tab[13] = '{dwv_pkg::OP_STOP, 32'd700, 32'd1, 32'd1, 16'd1, 16'd1, 1, 9'd0, 9'd0};
      dir_tab[14] = '{dwv_pkg::OP_SAMPLE, 32'd5000, 32'd0, 32'd0, 16'd0, 16'd0,
                      0, 9'd0, 9'd0};
      dir_tab[15] = '{dwv_pkg::OP_START, 32'd0, 32'd0, 32'd0, -16'sd220, 16'd221,
                      0, 9'd0, 9'd0};
      dir_tab[16] = '{dwv_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'd0, 16'd0,
                      0, 9'd0, 9'd0};
      dir_tab[17] = '{dwv_pkg::OP_STOP, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 1, 9'd0, 9'd0};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (dir_tab[i]) send_word(dir_tab[i]);
      drain();

      // Random phases, each under its own register setting
      ms_now = $urandom; odo[0] = $urandom; odo[1] = $urandom;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               csr_write(dwv_pkg::REG_PERIOD, 32'd1); csr_write(dwv_pkg::REG_KP, 32'hFFFF);
               csr_write(dwv_pkg::REG_KI, 32'hFFFF); csr_write(dwv_pkg::REG_KD, 32'hFFFF);
               csr_write(dwv_pkg::REG_LIMIT, 32'h3FF);
            end
            1: begin
               csr_write(dwv_pkg::REG_PERIOD, 32'hFFFF); csr_write(dwv_pkg::REG_KP, 32'd0);
               csr_write(dwv_pkg::REG_KI, 32'd0); csr_write(dwv_pkg::REG_KD, 32'd0);
               csr_write(dwv_pkg::REG_LIMIT, 32'd0);
            end
            2: csr_write(dwv_pkg::REG_PERIOD, 32'd0);
            default: begin
               csr_write(dwv_pkg::REG_PERIOD,
                         $urandom_range(1, 2000) | ($urandom & 32'hFFFF_0000));
               csr_write(dwv_pkg::REG_KP, $urandom_range(0, 600));
               csr_write(dwv_pkg::REG_KI, $urandom_range(0, 300));
               csr_write(dwv_pkg::REG_KD, $urandom_range(0, 200));
               csr_write(dwv_pkg::REG_LIMIT, $urandom);
            end
         endcase
         no_idle = (p == PHASES - 1);
         per_eff = period_r == 0 ? 1 : longint'(period_r);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (!run_on && pick >= 14 && $urandom_range(0, 9) < 7) pick = 0;
            row = '{dwv_pkg::OP_SAMPLE, ms_now, odo[0], odo[1], 16'($urandom),
                    16'($urandom), 0, 9'd0, 9'd0};
            if (pick < 6) begin
               row.op = dwv_pkg::OP_START;
               if ($urandom_range(0, 4) != 0) begin
                  row.sl = 16'($signed($urandom_range(0, 2 * limit_r + 20)) - limit_r - 10);
                  row.sr = 16'($signed($urandom_range(0, 2 * limit_r + 20)) - limit_r - 10);
               end
            end else if (pick < 10) begin
               row.op = dwv_pkg::OP_STOP;
            end else if (pick < 14) begin
               // noise: ignored op or a fully random sample
               row.op = pick < 12 ? dwv_pkg::OP_NONE : dwv_pkg::OP_SAMPLE;
               row.now = $urandom; row.ol = $urandom; row.orr = $urandom;
            end else begin
               step = per_eff + longint'($urandom_range(0, 32'(per_eff)));
               if (pick < 24) step = longint'($urandom_range(0, 32'(per_eff - 1)));
               else if (pick < 28) step = longint'($urandom);
               row.now = ms_now + 32'(step);
               span = (step * longint'(limit_r)) / 6000 + 50;
               if (span > 64'sd1000000) span = 64'sd1000000;
               for (int w = 0; w < 2; w++) begin
                  if ($urandom_range(0, 19) == 0)
                     odo[w] = $urandom;
                  else
                     odo[w] = odo[w] + 32'($urandom_range(0, 32'(2 * span)) - span);
               end
               row.ol = odo[0]; row.orr = odo[1];
            end
            if (row.op != dwv_pkg::OP_SAMPLE || pick >= 14) ms_now = row.now;
            send_word(row);
         end
         drain();
      end

      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
